@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the register port modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must never be seen.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/ppur_pkg.sv @@
// Types and constants of the video unit register port.
package ppur_pkg;

  localparam int VIDEO_MEM_DEPTH_DEF  = 16384;
  localparam int SPRITE_MEM_DEPTH_DEF = 256;
  localparam int ROW_STRIDE_DEF       = 32;

  localparam int PTR_W = 14;

  localparam logic [PTR_W-1:0] PAL_BASE   = 14'h3F00;
  localparam logic [PTR_W-1:0] PAL_MIRROR = 14'h3F10;
  localparam logic [7:0]       VSCROLL_LIMIT = 8'hF0;

  localparam int CTRL_STRIDE_BIT = 2;
  localparam int CTRL_NMI_BIT    = 7;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_VBLANK = 2'd2,
    OP_LINE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_SPR_ADDR = 3'd3,
    REG_SPR_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;  // latch operation, launch memory reads
    logic execute;  // apply update, write memories, load result
  } ppur_cmd_t;

endpackage

@@ hw/rtl/ppur_ctrl.sv @@
// Controller state machine of the register port.
`include "assert_macros.svh"

module ppur_ctrl import ppur_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ppur_cmd_t cmd,
  output logic      out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state_r == ST_EXEC);
    cmd.capture = (state_r == ST_IDLE) && start;
    cmd.execute = (state_r == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.execute;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.execute && busy)
  `ASSERT_NEXT(a_exec_then_strobe, cmd.execute, out_valid && !busy)
  `ASSERT_NEVER(a_capture_while_exec, cmd.capture && cmd.execute)

endmodule

@@ hw/rtl/ppur_datapath.sv @@
// Register file, sprite and video memories, and update logic of the register port.
`include "assert_macros.svh"

module ppur_datapath import ppur_pkg::*; #(
  parameter int VIDEO_MEM_DEPTH  = VIDEO_MEM_DEPTH_DEF,
  parameter int SPRITE_MEM_DEPTH = SPRITE_MEM_DEPTH_DEF,
  parameter int ROW_STRIDE       = ROW_STRIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ppur_cmd_t  cmd,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic       in_line_sprite_hit,
  input  logic       in_line_overflow,
  output logic [7:0] out_read_data,
  output logic       out_nmi_request,
  output logic [7:0] out_scroll_x,
  output logic [7:0] out_scroll_y
);

  localparam int VA_W = $clog2(VIDEO_MEM_DEPTH);
  localparam int SA_W = $clog2(SPRITE_MEM_DEPTH);
  localparam logic [PTR_W-1:0] STRIDE_INC = PTR_W'(ROW_STRIDE);

  // latched operation
  op_t        op_r;
  reg_t       reg_r;
  logic [7:0] wdata_r;
  logic       line_hit_r;
  logic       line_ovf_r;

  // architectural registers
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [7:0] buf_r, buf_nxt;
  logic       toggle_r, toggle_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] last_r, last_nxt;
  logic [7:0] spr_ptr_r, spr_ptr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] hscroll_r, hscroll_nxt;
  logic [7:0] vscroll_r, vscroll_nxt;
  logic       vblank_r, vblank_nxt;
  logic       hit_r, hit_nxt;
  logic       ovf_r, ovf_nxt;

  logic [7:0] rd_r, rd_nxt;
  logic       nmi_r, nmi_nxt;

  // memories
  logic [7:0] video_mem [VIDEO_MEM_DEPTH];
  logic [7:0] sprite_mem [SPRITE_MEM_DEPTH];
  logic [7:0] vid_q_r, spr_q_r;
  logic [PTR_W-1:0] vid_cell;
  logic [VA_W-1:0]  vid_addr;
  logic [SA_W-1:0]  spr_addr;
  logic vid_we, spr_we;

  // palette entry 0x3F10 shares the cell of 0x3F00
  assign vid_cell = (ptr_r == PAL_MIRROR) ? PAL_BASE : ptr_r;
  assign vid_addr = vid_cell[VA_W-1:0];
  assign spr_addr = spr_ptr_r[SA_W-1:0];

  assign vid_we = cmd.execute && (op_r == OP_WRITE) && (reg_r == REG_DATA);
  assign spr_we = cmd.execute && (op_r == OP_WRITE) && (reg_r == REG_SPR_DATA);

  always_ff @(posedge clk) begin
    if (vid_we) video_mem[vid_addr] <= wdata_r;
    if (cmd.capture) vid_q_r <= video_mem[vid_addr];
  end

  always_ff @(posedge clk) begin
    if (spr_we) sprite_mem[spr_addr] <= wdata_r;
    if (cmd.capture) spr_q_r <= sprite_mem[spr_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_opcode);
      reg_r      <= reg_t'(in_reg_index);
      wdata_r    <= in_write_data;
      line_hit_r <= in_line_sprite_hit;
      line_ovf_r <= in_line_overflow;
    end
  end

  always_comb begin
    ptr_nxt     = ptr_r;
    buf_nxt     = buf_r;
    toggle_nxt  = toggle_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    last_nxt    = last_r;
    spr_ptr_nxt = spr_ptr_r;
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    hscroll_nxt = hscroll_r;
    vscroll_nxt = vscroll_r;
    vblank_nxt  = vblank_r;
    hit_nxt     = hit_r;
    ovf_nxt     = ovf_r;
    rd_nxt      = 8'd0;
    nmi_nxt     = 1'b0;

    unique case (op_r)
      OP_READ: begin
        unique case (reg_r)
          REG_STATUS: begin
            rd_nxt     = {vblank_r, hit_r, ovf_r, last_r[4:0]};
            vblank_nxt = 1'b0;
            toggle_nxt = 1'b0;
          end
          REG_SPR_DATA: begin
            rd_nxt      = spr_q_r;
            spr_ptr_nxt = spr_ptr_r + 8'd1;
          end
          REG_DATA: begin
            // below the palette the buffer is returned and refilled
            rd_nxt  = (ptr_r < PAL_BASE) ? buf_r : vid_q_r;
            buf_nxt = vid_q_r;
            ptr_nxt = ptr_r + PTR_W'(1);
          end
          default: begin
          end
        endcase
      end
      OP_WRITE: begin
        unique case (reg_r)
          REG_CTRL:     ctrl_nxt    = wdata_r;
          REG_MASK:     mask_nxt    = wdata_r;
          REG_SPR_ADDR: spr_ptr_nxt = wdata_r;
          REG_SPR_DATA: spr_ptr_nxt = spr_ptr_r + 8'd1;
          REG_SCROLL: begin
            if (!toggle_r) hscroll_nxt = wdata_r;
            else if (wdata_r < VSCROLL_LIMIT) vscroll_nxt = wdata_r;
            toggle_nxt = !toggle_r;
          end
          REG_ADDR: begin
            last_nxt = wdata_r;
            if (!toggle_r) hi_nxt = wdata_r;
            else lo_nxt = wdata_r;
            toggle_nxt = !toggle_r;
            ptr_nxt    = PTR_W'({hi_nxt, lo_nxt});
          end
          REG_DATA: begin
            ptr_nxt = ctrl_r[CTRL_STRIDE_BIT] ? (ptr_r + STRIDE_INC) : (ptr_r + PTR_W'(1));
          end
          default: begin
          end
        endcase
      end
      OP_VBLANK: begin
        vblank_nxt  = 1'b1;
        hit_nxt     = 1'b0;
        spr_ptr_nxt = 8'd0;
        nmi_nxt     = ctrl_r[CTRL_NMI_BIT];
      end
      OP_LINE: begin
        vblank_nxt = 1'b0;
        hit_nxt    = hit_r | line_hit_r;
        ovf_nxt    = line_ovf_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      buf_r     <= '0;
      toggle_r  <= 1'b0;
      hi_r      <= '0;
      lo_r      <= '0;
      last_r    <= '0;
      spr_ptr_r <= '0;
      ctrl_r    <= '0;
      mask_r    <= '0;
      hscroll_r <= '0;
      vscroll_r <= '0;
      vblank_r  <= 1'b0;
      hit_r     <= 1'b0;
      ovf_r     <= 1'b0;
      rd_r      <= '0;
      nmi_r     <= 1'b0;
    end else if (cmd.execute) begin
      ptr_r     <= ptr_nxt;
      buf_r     <= buf_nxt;
      toggle_r  <= toggle_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      last_r    <= last_nxt;
      spr_ptr_r <= spr_ptr_nxt;
      ctrl_r    <= ctrl_nxt;
      mask_r    <= mask_nxt;
      hscroll_r <= hscroll_nxt;
      vscroll_r <= vscroll_nxt;
      vblank_r  <= vblank_nxt;
      hit_r     <= hit_nxt;
      ovf_r     <= ovf_nxt;
      rd_r      <= rd_nxt;
      nmi_r     <= nmi_nxt;
    end
  end

  assign out_read_data   = rd_r;
  assign out_nmi_request = nmi_r;
  assign out_scroll_x    = hscroll_r;
  assign out_scroll_y    = vscroll_r;

  `ASSERT_NEVER(a_vscroll_range, vscroll_r >= VSCROLL_LIMIT)
  `ASSERT_NEXT(a_status_clears, cmd.execute && (op_r == OP_READ) && (reg_r == REG_STATUS),
               !vblank_r && !toggle_r)
  `ASSERT_NEXT(a_nmi_only_vblank, cmd.execute && (op_r != OP_VBLANK), !nmi_r)
  `ASSERT_IMPL(a_state_holds, !cmd.execute && !$past(cmd.execute) && $past(rst_n),
               $stable(ptr_r) && $stable(spr_ptr_r))

endmodule

@@ hw/rtl/ppu_register_port_top.sv @@
// An accepted transfer passes through the EXEC state and then the out_valid register before its result strobe.
// A new operation is not accepted while busy; busy is high for the cycle after acceptance.
// The capture step reads video and sprite memory, the execute step applies the update and writes.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears the architectural and result registers and the state machine;
// video and sprite memories are not cleared and hold unknown data until written.
module ppu_register_port_top import ppur_pkg::*; #(
  parameter int VIDEO_MEM_DEPTH  = VIDEO_MEM_DEPTH_DEF,
  parameter int SPRITE_MEM_DEPTH = SPRITE_MEM_DEPTH_DEF,
  parameter int ROW_STRIDE       = ROW_STRIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic       in_line_sprite_hit,
  input  logic       in_line_overflow,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_nmi_request,
  output logic [7:0] out_scroll_x,
  output logic [7:0] out_scroll_y
);

  ppur_cmd_t cmd;

  ppur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  ppur_datapath #(
    .VIDEO_MEM_DEPTH  (VIDEO_MEM_DEPTH),
    .SPRITE_MEM_DEPTH (SPRITE_MEM_DEPTH),
    .ROW_STRIDE       (ROW_STRIDE)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_opcode          (in_opcode),
    .in_reg_index       (in_reg_index),
    .in_write_data      (in_write_data),
    .in_line_sprite_hit (in_line_sprite_hit),
    .in_line_overflow   (in_line_overflow),
    .out_read_data      (out_read_data),
    .out_nmi_request    (out_nmi_request),
    .out_scroll_x       (out_scroll_x),
    .out_scroll_y       (out_scroll_y)
  );

endmodule
